/* hdl/token_expiry_table_assert.svh */
// Assertion macros for the token expiry table
`ifndef TOKEN_EXPIRY_TABLE_ASSERT_SVH
`define TOKEN_EXPIRY_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define TET_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("token_expiry_table: same-cycle check failed");
`define TET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("token_expiry_table: next-cycle check failed");
`else
`define TET_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TET_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/tet_pkg.sv */
package tet_pkg;

	localparam int TOKENS_DEF = 64;
	localparam int KEY_W      = 25;
	localparam int TIME_W     = 30;
	localparam int EXP_W      = 31;
	localparam int CNT_OUT_W  = 7;
	localparam int CNT_MAX    = 127;

	localparam logic [1:0] FUNC_GENERATE = 2'd0;
	localparam logic [1:0] FUNC_RENEW    = 2'd1;
	localparam logic [1:0] FUNC_QUERY    = 2'd2;

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_IGNORED = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [KEY_W-1:0]  token_key;
		logic [TIME_W-1:0] current_time;
	} in_item_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [CNT_OUT_W-1:0] unexpired_count;
	} out_item_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [EXP_W-1:0] expiry;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_FINISH
	} state_t;

endpackage

/* hdl/token_expiry_table.sv */
// Flow: an accepted input beat passes the SCAN, WAIT and FINISH states, and the result
// is registered in FINISH once the output is free. Input stays stalled until then; the
// single memory read port scans one entry per cycle, then FINISH applies the operation.
// Reset: arst_n clears control state and time_to_live to 1, then a clearing pass over
// all TOKENS entries zeroes the table while input stays stalled.
`include "token_expiry_table_assert.svh"

module token_expiry_table #(
	parameter int TOKENS = tet_pkg::TOKENS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tet_pkg::TIME_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  tet_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output tet_pkg::out_item_t        out_data
);
	import tet_pkg::*;

	localparam int IDX_W = (TOKENS > 1) ? $clog2(TOKENS) : 1;
	localparam int CNT_W = $clog2(TOKENS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOKENS - 1);

	entry_t mem [TOKENS];

	state_t state_q, state_nxt;

	logic [TIME_W-1:0] ttl_q;
	in_item_t          item_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  clr_idx_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	entry_t            rd_data_s1;
	logic              hit_q, free_q;
	logic [IDX_W-1:0]  hit_slot_q, free_slot_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              accept, out_free, alive;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	entry_t            mem_wd;
	logic              fin_we, fin_ins;
	logic [IDX_W-1:0]  fin_slot;
	logic [1:0]        fin_status;
	logic [EXP_W-1:0]  new_expiry;
	logic [CNT_W-1:0]  cnt_final;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign alive    = rd_data_s1.valid && (rd_data_s1.expiry > {1'b0, item_q.current_time});

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_idx_q == LAST_IDX) state_nxt = ST_IDLE;
			ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
			ST_SCAN:   if (rd_idx_q == LAST_IDX) state_nxt = ST_WAIT;
			ST_WAIT:   state_nxt = ST_FINISH;
			ST_FINISH: if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_CLEAR;
		endcase
	end

	// outputs and memory write control
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		new_expiry = {1'b0, item_q.current_time} + {1'b0, ttl_q};
		fin_we     = 1'b0;
		fin_ins    = 1'b0;
		fin_slot   = hit_slot_q;
		fin_status = STATUS_DONE;
		case (item_q.func)
			FUNC_GENERATE: begin
				if (hit_q) begin
					fin_we = 1'b1;
				end else if (free_q) begin
					fin_we   = 1'b1;
					fin_ins  = 1'b1;
					fin_slot = free_slot_q;
				end else begin
					fin_status = STATUS_FULL;
				end
			end
			FUNC_RENEW: begin
				if (hit_q) fin_we = 1'b1;
				else       fin_status = STATUS_IGNORED;
			end
			default: fin_we = 1'b0;
		endcase
		cnt_final = count_q + CNT_W'(fin_ins);

		mem_we = 1'b0;
		mem_wa = idx_s1;
		mem_wd = rd_data_s1;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_idx_q;
				mem_wd = '0;
			end
			ST_SCAN, ST_WAIT: begin
				// drop an expired entry as it streams past
				if (rd_vld_s1 && rd_data_s1.valid && !alive) begin
					mem_we       = 1'b1;
					mem_wd.valid = 1'b0;
				end
			end
			ST_FINISH: begin
				mem_we = out_free && fin_we;
				mem_wa = fin_slot;
				mem_wd = '{valid: 1'b1, key: item_q.token_key, expiry: new_expiry};
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_data_s1 <= mem[rd_idx_q];
		idx_s1     <= rd_idx_q;
		if (accept) item_q <= in_data;
		if (state_q == ST_FINISH && out_free) begin
			out_q.status <= fin_status;
			out_q.unexpired_count <= (32'(cnt_final) > CNT_MAX) ? CNT_OUT_W'(CNT_MAX)
				: CNT_OUT_W'(cnt_final);
		end
		if (accept) begin
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			count_q <= '0;
		end else if (rd_vld_s1) begin
			if (alive) begin
				count_q <= count_q + CNT_W'(1);
				if (!hit_q && rd_data_s1.key == item_q.token_key) begin
					hit_q      <= 1'b1;
					hit_slot_q <= idx_s1;
				end
			end else if (!free_q) begin
				free_q      <= 1'b1;
				free_slot_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ttl_q       <= TIME_W'(1);
			clr_idx_q   <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (cfg_we) ttl_q <= cfg_data;
			if (state_q == ST_CLEAR) clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (accept) rd_idx_q <= '0;
			else if (state_q == ST_SCAN && rd_idx_q != LAST_IDX) rd_idx_q <= rd_idx_q + IDX_W'(1);
			if (state_q == ST_FINISH && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`TET_ASSERT_NEXT(a_accept_scans, clk, arst_n, accept, state_q == ST_SCAN && rd_idx_q == '0)
	`TET_ASSERT_SAME(a_no_scan_at_finish, clk, arst_n, state_q == ST_FINISH, !rd_vld_s1)
	`TET_ASSERT_SAME(a_count_bound, clk, arst_n, rd_vld_s1, 32'(count_q) <= TOKENS)
	`TET_ASSERT_SAME(a_stall_when_busy, clk, arst_n, state_q != ST_IDLE, in_stall)

endmodule

/* verif/tb_token_expiry_table.sv */
module tb_token_expiry_table;
	import tet_pkg::*;

	localparam int SLOTS        = TOKENS_DEF;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int SETTLE_CYCLES = SLOTS + 16;
	localparam int HOLD_CYCLES  = 900;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [TIME_W-1:0] TTL_MAX = '1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef enum int {RX_FREE, RX_HALF, RX_BUSY, RX_PERIODIC} rx_mode_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [TIME_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_item_t          in_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_data;

	token_expiry_table #(.TOKENS(SLOTS)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// shadow of the table and the lifetime register
	bit               slot_live   [SLOTS];
	bit [KEY_W-1:0]   slot_key    [SLOTS];
	bit [EXP_W-1:0]   slot_expiry [SLOTS];
	bit [TIME_W-1:0]  ttl_shadow = TIME_W'(1);

	in_item_t  pending_requests [$];
	out_item_t expected_results [$];
	out_item_t want_result;
	int        mismatch_count = 0;
	int        results_seen = 0;
	int        cycle_count = 0;

	function automatic out_item_t apply_request(in_item_t req);
		bit [EXP_W-1:0] new_expiry;
		bit             hit;
		bit             has_free;
		int             hit_slot;
		int             free_slot;
		int             live;
		out_item_t      res;
		new_expiry = EXP_W'(req.current_time) + EXP_W'(ttl_shadow);
		hit = 1'b0;
		has_free = 1'b0;
		hit_slot = 0;
		free_slot = 0;
		live = 0;
		// expiry purge and lookup in one pass, lowest slot wins
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_live[i] && slot_expiry[i] <= EXP_W'(req.current_time))
				slot_live[i] = 1'b0;
			if (slot_live[i]) begin
				if (!hit && slot_key[i] == req.token_key) begin
					hit = 1'b1;
					hit_slot = i;
				end
			end else if (!has_free) begin
				has_free = 1'b1;
				free_slot = i;
			end
		end
		res.status = STATUS_DONE;
		case (req.func)
			FUNC_GENERATE: begin
				if (hit) begin
					slot_expiry[hit_slot] = new_expiry;
				end else if (has_free) begin
					slot_live[free_slot] = 1'b1;
					slot_key[free_slot] = req.token_key;
					slot_expiry[free_slot] = new_expiry;
				end else begin
					res.status = STATUS_FULL;
				end
			end
			FUNC_RENEW: begin
				if (hit)
					slot_expiry[hit_slot] = new_expiry;
				else
					res.status = STATUS_IGNORED;
			end
			default: ;
		endcase
		for (int i = 0; i < SLOTS; i++)
			if (slot_live[i])
				live++;
		if (live > CNT_MAX)
			live = CNT_MAX;
		res.unexpired_count = CNT_OUT_W'(live);
		return res;
	endfunction

	// input beats: predict on acceptance
	bit beat_taken = 1'b0;
	always @(posedge clk) begin
		beat_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			expected_results.push_back(apply_request(in_data));
	end

	// sender: bursts with random gaps
	int gap_left = 0;
	int burst_left = 0;
	always @(negedge clk) begin
		if (!in_valid || beat_taken) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending_requests.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pending_requests.pop_front();
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 8);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall modes, plus one long hold-off mid run
	rx_mode_t rx_mode = RX_FREE;
	int       mode_left = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (!hold_done && results_seen >= 300) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(40, 400);
			end
			mode_left--;
			case (rx_mode)
				RX_FREE:     out_stall <= 1'b0;
				RX_HALF:     out_stall <= $urandom_range(0, 1);
				RX_BUSY:     out_stall <= ($urandom_range(0, 9) != 0);
				RX_PERIODIC: out_stall <= (mode_left % 4 == 0);
				default:     out_stall <= 1'b0;
			endcase
		end
	end

	// result beats
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("unexpected beat: status=%0d unexpired_count=%0d",
					out_data.status, out_data.unexpired_count);
				mismatch_count++;
			end else begin
				want_result = expected_results.pop_front();
				if (out_data.status !== want_result.status) begin
					$error("status: expected %0d, got %0d",
						want_result.status, out_data.status);
					mismatch_count++;
				end
				if (out_data.unexpired_count !== want_result.unexpired_count) begin
					$error("unexpired_count: expected %0d, got %0d",
						want_result.unexpired_count, out_data.unexpired_count);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	logic [TIME_W-1:0] now_t = '0;
	bit [KEY_W-1:0]    recent_keys [16];
	int                recent_wr = 0;

	task automatic queue_request(input logic [1:0] func, input logic [KEY_W-1:0] key,
			input logic [TIME_W-1:0] at);
		in_item_t req;
		req.func = func;
		req.token_key = key;
		req.current_time = at;
		pending_requests.push_back(req);
		if (func == FUNC_GENERATE) begin
			recent_keys[recent_wr] = key;
			recent_wr = (recent_wr + 1) % 16;
		end
	endtask

	task automatic wait_idle();
		while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_lifetime(input logic [TIME_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= value;
		ttl_shadow = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mixed traffic, with fill runs of many fresh keys close together to drive the table full
	task automatic run_phase(input int count);
		int                seg_left;
		bit                seg_fill;
		int                pick;
		int                step_max;
		logic [1:0]        func;
		logic [KEY_W-1:0]  key;
		seg_left = 0;
		seg_fill = 1'b0;
		step_max = (ttl_shadow / 20 > 1) ? int'(ttl_shadow / 20) : 1;
		for (int n = 0; n < count; n++) begin
			if (seg_left == 0) begin
				seg_fill = ($urandom_range(0, 3) == 0);
				seg_left = $urandom_range(10, 70);
			end
			seg_left--;
			if ($urandom_range(0, 99) < 4)
				now_t = TIME_W'($urandom);
			else
				now_t = now_t + TIME_W'($urandom_range(0, step_max));
			if (seg_fill) begin
				func = FUNC_GENERATE;
				key = ($urandom_range(0, 7) == 0) ? recent_keys[$urandom_range(0, 15)]
					: KEY_W'($urandom);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					func = FUNC_GENERATE;
				else if (pick < 75)
					func = FUNC_RENEW;
				else if (pick < 93)
					func = FUNC_QUERY;
				else
					func = FUNC_UNUSED;
				pick = $urandom_range(0, 99);
				if (pick < 80)
					key = recent_keys[$urandom_range(0, 15)];
				else if (pick < 90)
					key = KEY_W'($urandom);
				else if (pick < 95)
					key = '0;
				else
					key = '1;
			end
			queue_request(func, key, now_t);
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// lifetime of one: expiry right after the write time
		queue_request(FUNC_GENERATE, '0, '0);
		queue_request(FUNC_QUERY, '0, '0);
		queue_request(FUNC_RENEW, '0, '0);
		queue_request(FUNC_GENERATE, '1, 30'd5);
		queue_request(FUNC_UNUSED, 25'h0AB_CDEF, 30'd5);
		queue_request(FUNC_RENEW, '0, 30'd5);
		queue_request(FUNC_QUERY, '0, 30'd6);
		queue_request(FUNC_GENERATE, 25'h155_5555, TIME_MAX);
		queue_request(FUNC_QUERY, '0, TIME_MAX - 1);
		queue_request(FUNC_RENEW, 25'h155_5555, TIME_MAX);
		queue_request(FUNC_GENERATE, 25'h0AA_AAAA, 30'h2AAA_AAAA);
		queue_request(FUNC_QUERY, '1, 30'h1555_5555);

		// zero lifetime: counted once, gone on the next beat
		set_lifetime('0);
		queue_request(FUNC_GENERATE, 25'd3, 30'd100);
		queue_request(FUNC_QUERY, 25'd3, 30'd100);
		queue_request(FUNC_GENERATE, 25'd3, 30'd100);
		queue_request(FUNC_RENEW, 25'd3, 30'd100);
		queue_request(FUNC_GENERATE, 25'd3, 30'd99);

		set_lifetime(TTL_MAX);
		queue_request(FUNC_GENERATE, '1, TIME_MAX);
		queue_request(FUNC_RENEW, '1, '0);
		queue_request(FUNC_GENERATE, '1, 30'd7);
		queue_request(FUNC_QUERY, '0, TIME_MAX);

		now_t = 30'd1000;
		set_lifetime(30'd1);
		run_phase(180);
		set_lifetime('0);
		run_phase(150);
		set_lifetime(30'd3000);
		run_phase(340);
		set_lifetime(TIME_W'($urandom_range(2, 1 << 20)));
		run_phase(260);
		set_lifetime(30'd200000);
		run_phase(320);
		// long-lived entries never expire, so this phase runs last
		set_lifetime(TTL_MAX);
		run_phase(200);

		wait_idle();
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/tet_pkg.sv
hdl/token_expiry_table.sv
verif/tb_token_expiry_table.sv
